[rtl/iir2_pkg.sv]
package iir2_pkg;

  localparam int COEF_BITS  = 32;
  localparam int NUM_COEFFS = 5;
  localparam int CIDX_BITS  = 3;

  typedef logic [CIDX_BITS-1:0] coef_idx_t;

  // Coefficient register indexes
  localparam coef_idx_t CI_DIRECT = 3'd0;
  localparam coef_idx_t CI_IN1    = 3'd1;
  localparam coef_idx_t CI_FB1    = 3'd2;
  localparam coef_idx_t CI_IN2    = 3'd3;
  localparam coef_idx_t CI_FB2    = 3'd4;

  typedef enum logic [1:0] {
    ADD_D1,
    ADD_D2,
    ADD_ACC
  } add_src_t;

  typedef struct packed {
    logic      load;         // capture the new sample, start c0*x
    coef_idx_t mul_coef;
    logic      mul_from_y;   // multiply by the rounded output instead of x
    add_src_t  add_src;
    logic      acc_from_add;
    logic      round;
    logic      d2_from_p;
    logic      d1_from_add;
    logic      d2_from_add;
    logic      publish;      // move the result into the output register
  } iir2_ctrl_t;

endpackage

[rtl/iir2_if.sv]
interface iir2_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface iir2_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;
  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

interface iir2_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/second_order_iir_filter.sv]
// Biquad IIR section, transposed direct form II, Q1.15 samples in and out.
//
// Channels:
//   din  - one signed sample per item (valid/ready).
//   dout - filtered sample plus a clipped flag, one item per input item.
//   cfg  - coefficient writes, index 0..4 = direct, input->first delay,
//          feedback->first delay, input->second delay, feedback->second delay.
//          cfg.ready is always high; indexes above 4 are dropped. Any valid
//          coefficient write clears both delays. Write only while idle.
// Schedule: one multiplier and one saturating adder are shared over the five
//   products, so each item passes through the accept cycle and the five
//   sequencer steps ACC0, RND, MOV, D1 and D2. dout.valid is registered from
//   the publish strobe of D2 (or of HOLD on a stall), and din.ready is low
//   from acceptance until the sequencer is back in IDLE.
// Stall: dout is a register; a new item is accepted while a result waits.
//   If that item completes before the old result is taken, the block holds
//   it and keeps din.ready low until the output register frees up.
// Reset: coefficients return to a unity pass-through, delays clear, no
//   result is pending.
module second_order_iir_filter
  import iir2_pkg::*;
#(
  parameter int SAMPLE_BITS     = 16,
  parameter int COEFF_FRAC_BITS = 28
) (
  input logic                          clk,
  input logic                          rst,
  iir2_in_if.sink                      din,
  iir2_out_if.source                   dout,
  iir2_cfg_if.sink                     cfg
);

  iir2_ctrl_t ctrl;

  assign cfg.ready = 1'b1;

  iir2_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_ready (dout.ready),
    .out_valid (dout.valid),
    .ctrl      (ctrl)
  );

  iir2_datapath #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .sample_in  (din.sample_in),
    .cfg_we     (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .sample_out (dout.sample_out),
    .clipped    (dout.clipped)
  );

endmodule

[rtl/iir2_seq.sv]
module iir2_seq
  import iir2_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  output iir2_ctrl_t ctrl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC0,
    S_RND,
    S_MOV,
    S_D1,
    S_D2,
    S_HOLD
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    ctrl          = '0;
    ctrl.add_src  = ADD_D1;
    ctrl.mul_coef = CI_DIRECT;
    state_next    = state;
    case (state)
      S_IDLE: begin
        ctrl.load = in_valid;
        if (in_valid) state_next = S_ACC0;
      end
      S_ACC0: begin
        ctrl.add_src      = ADD_D1;
        ctrl.acc_from_add = 1'b1;
        ctrl.mul_coef     = CI_IN1;
        state_next        = S_RND;
      end
      S_RND: begin
        // acc now becomes the partial first delay
        ctrl.round        = 1'b1;
        ctrl.add_src      = ADD_D2;
        ctrl.acc_from_add = 1'b1;
        ctrl.mul_coef     = CI_IN2;
        state_next        = S_MOV;
      end
      S_MOV: begin
        ctrl.d2_from_p  = 1'b1;
        ctrl.mul_coef   = CI_FB1;
        ctrl.mul_from_y = 1'b1;
        state_next      = S_D1;
      end
      S_D1: begin
        ctrl.add_src     = ADD_ACC;
        ctrl.d1_from_add = 1'b1;
        ctrl.mul_coef    = CI_FB2;
        ctrl.mul_from_y  = 1'b1;
        state_next       = S_D2;
      end
      S_D2: begin
        ctrl.add_src     = ADD_D2;
        ctrl.d2_from_add = 1'b1;
        ctrl.publish     = slot_free;
        state_next       = slot_free ? S_IDLE : S_HOLD;
      end
      S_HOLD: begin
        ctrl.publish = slot_free;
        if (slot_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= ctrl.publish || (out_valid && !out_ready);
    end
  end

endmodule

[rtl/iir2_datapath.sv]
module iir2_datapath
  import iir2_pkg::*;
#(
  parameter int SAMPLE_BITS     = 16,
  parameter int COEFF_FRAC_BITS = 28
) (
  input  logic                          clk,
  input  logic                          rst,
  input  iir2_ctrl_t                    ctrl,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          cfg_we,
  input  logic [CIDX_BITS-1:0]          cfg_index,
  input  logic [COEF_BITS-1:0]          cfg_data,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          clipped
);

  localparam int ACC_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int QW       = ACC_BITS - COEFF_FRAC_BITS;
  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [COEF_BITS-1:0] GAIN_ONE = COEF_BITS'(64'd1 << COEFF_FRAC_BITS);

  logic signed [COEF_BITS-1:0]   coef [NUM_COEFFS];
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] yq;
  logic signed [ACC_BITS-1:0]    p;
  logic signed [ACC_BITS-1:0]    acc;
  logic signed [ACC_BITS-1:0]    d1;
  logic signed [ACC_BITS-1:0]    d2;
  logic                          flag;
  logic                          flag_next;

  logic signed [COEF_BITS-1:0]   coef_op;
  logic signed [SAMPLE_BITS-1:0] mand_op;
  logic signed [ACC_BITS-1:0]    prod;
  logic signed [ACC_BITS-1:0]    add_a;
  logic signed [ACC_BITS:0]      sum;
  logic                          add_ovf;
  logic signed [ACC_BITS-1:0]    add_res;
  logic                          add_use;
  logic signed [QW-1:0]          q_sh;
  logic signed [QW:0]            rnd;
  logic [QW-SAMPLE_BITS+1:0]     rnd_top;
  logic                          rnd_ovf;
  logic signed [SAMPLE_BITS-1:0] rnd_val;

  // Shared multiplier: product always fits the accumulator width
  assign coef_op = coef[ctrl.mul_coef];
  assign mand_op = ctrl.load ? sample_in : (ctrl.mul_from_y ? yq : x);
  assign prod    = ACC_BITS'(coef_op) * ACC_BITS'(mand_op);

  // Shared saturating adder, second operand is always the product register
  always_comb begin
    case (ctrl.add_src)
      ADD_D1:  add_a = d1;
      ADD_D2:  add_a = d2;
      ADD_ACC: add_a = acc;
      default: add_a = d1;
    endcase
  end

  assign sum     = {add_a[ACC_BITS-1], add_a} + {p[ACC_BITS-1], p};
  assign add_ovf = sum[ACC_BITS] != sum[ACC_BITS-1];
  assign add_res = add_ovf ? (sum[ACC_BITS] ? ACC_MIN : ACC_MAX) : sum[ACC_BITS-1:0];
  assign add_use = ctrl.acc_from_add || ctrl.d1_from_add || ctrl.d2_from_add;

  // Round half up, then saturate to the sample range
  assign q_sh    = acc[ACC_BITS-1:COEFF_FRAC_BITS];
  assign rnd     = {q_sh[QW-1], q_sh} + (QW+1)'(acc[COEFF_FRAC_BITS-1]);
  assign rnd_top = rnd[QW:SAMPLE_BITS-1];
  assign rnd_ovf = !((&rnd_top) || !(|rnd_top));
  assign rnd_val = rnd_ovf ? (rnd[QW] ? SMP_MIN : SMP_MAX) : rnd[SAMPLE_BITS-1:0];

  assign flag_next = ctrl.load ? 1'b0
                   : (flag || (add_use && add_ovf) || (ctrl.round && rnd_ovf));

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0] <= GAIN_ONE;
      for (int i = 1; i < NUM_COEFFS; i++) coef[i] <= '0;
      d1   <= '0;
      d2   <= '0;
      flag <= 1'b0;
    end else begin
      flag <= flag_next;
      if (cfg_we && (cfg_index < CIDX_BITS'(NUM_COEFFS))) begin
        // any coefficient write restarts the filter
        coef[cfg_index] <= cfg_data;
        d1 <= '0;
        d2 <= '0;
      end else begin
        if (ctrl.d1_from_add) d1 <= add_res;
        if (ctrl.d2_from_p) begin
          d2 <= p;
        end else if (ctrl.d2_from_add) begin
          d2 <= add_res;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    p <= prod;
    if (ctrl.load) x <= sample_in;
    if (ctrl.acc_from_add) acc <= add_res;
    if (ctrl.round) yq <= rnd_val;
    if (ctrl.publish) begin
      sample_out <= yq;
      clipped    <= flag_next;
    end
  end

endmodule

[rtl/iir2_checker.sv]
module iir2_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] sample_out,
  input logic                   clipped
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // busy for the five sequencer steps after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> ##1 !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input taken while the sequencer is busy");

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> ##6 out_valid)
    else $error("no result six cycles after an accepted item");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(clipped))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid)
    else $error("result pending right after reset");

endmodule

bind second_order_iir_filter iir2_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_iir2_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (din.valid),
  .in_ready   (din.ready),
  .out_valid  (dout.valid),
  .out_ready  (dout.ready),
  .sample_out (dout.sample_out),
  .clipped    (dout.clipped)
);
